[rtl/hsss_pkg.sv]
// Package for the HBlank scroll split sequencer.
// Holds the operation codes, request structs and the split table entry type.
// No dependencies.
package hsss_pkg;

  // Operation codes carried in the input request
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ARM    = 2'd1,
    OP_TICK   = 2'd2,
    OP_DISARM = 2'd3
  } op_e;

  // Lowest tick count a chain starts with (first line of zero fires on one tick)
  localparam logic [7:0] TICKS_MIN = 8'h01;

  // Input request
  typedef struct packed {
    op_e        operation;
    logic [3:0] entry_index;
    logic [7:0] split_line;
    logic [7:0] plane1_scroll_x;
    logic [7:0] plane1_scroll_y;
    logic [7:0] plane2_scroll_x;
    logic [7:0] plane2_scroll_y;
    logic [7:0] arm_count;
  } in_req_t;

  // Output request
  typedef struct packed {
    logic [7:0] out_plane1_x;
    logic [7:0] out_plane1_y;
    logic [7:0] out_plane2_x;
    logic [7:0] out_plane2_y;
    logic [3:0] fired_split;
    logic       chain_done;
  } out_req_t;

  // One split table entry
  typedef struct packed {
    logic [7:0] line;
    logic [7:0] p1x;
    logic [7:0] p1y;
    logic [7:0] p2x;
    logic [7:0] p2y;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

endpackage

[rtl/hblank_scroll_split_sequencer.sv]
// Top level of the HBlank scroll split sequencer: sequencer core plus the split
// table, kept as two mirrored RAMs for two reads a cycle. Depends on hsss_pkg,
// hsss_ram and hsss_seq.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i / in_ready_o   | in_req_i  (in_req_t)
//  out     | output    | out_valid_o / out_ready_i | out_req_o (out_req_t)
//
// A request is taken every cycle unless stalled; each sits in the request stage
// while its table reads (current entry, next entry line) come back from the RAMs.
// A firing tick passes through the request stage into the output register.
// Reset clears the chain state and empties the stage; the table is not cleared.
// in_ready_o drops only while a firing split waits on a full output register.
module hblank_scroll_split_sequencer
  import hsss_pkg::*;
#(
  parameter int unsigned MAX_SPLITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  localparam int unsigned IW = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr_a;
  logic [IW-1:0] ram_raddr_b;
  entry_t        ram_rdata_a;
  logic [7:0]    ram_rline_b;

  // Sequencer core
  hsss_seq #(
    .MAX_SPLITS (MAX_SPLITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_req_o     (out_req_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rline_b_i (ram_rline_b)
  );

  // Full entries, read at the current split
  hsss_ram #(
    .WIDTH (EntryBits),
    .DEPTH (MAX_SPLITS)
  ) u_ram_entry (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr_a),
    .rdata_o (ram_rdata_a)
  );

  // Line mirror, read at the following split
  hsss_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SPLITS)
  ) u_ram_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata.line),
    .re_i    (ram_re),
    .raddr_i (ram_raddr_b),
    .rdata_o (ram_rline_b)
  );

endmodule

[rtl/hsss_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hsss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hsss_seq.sv]
// Sequencer core: request stage, chain state, table read/write control and
// the output register. Depends on hsss_pkg; the table lives in hsss_ram outside.
module hsss_seq
  import hsss_pkg::*;
#(
  parameter int unsigned MAX_SPLITS = 16
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  in_req_t                                            in_req_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output out_req_t                                           out_req_o,
  output logic                                               ram_we_o,
  output logic [(MAX_SPLITS > 1 ? $clog2(MAX_SPLITS) : 1)-1:0] ram_waddr_o,
  output entry_t                                             ram_wdata_o,
  output logic                                               ram_re_o,
  output logic [(MAX_SPLITS > 1 ? $clog2(MAX_SPLITS) : 1)-1:0] ram_raddr_a_o,
  output logic [(MAX_SPLITS > 1 ? $clog2(MAX_SPLITS) : 1)-1:0] ram_raddr_b_o,
  input  entry_t                                             ram_rdata_a_i,
  input  logic [7:0]                                         ram_rline_b_i
);

  localparam int unsigned IW = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
  localparam int unsigned CW = $clog2(MAX_SPLITS + 1);

  // Request stage: the request whose table reads are in flight
  logic       s1_v_q, s1_v_d;
  op_e        s1_op_q;
  logic [7:0] s1_cnt_q;

  // Chain state
  logic [CW-1:0] active_q, active_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [7:0]    ticks_q, ticks_d;
  logic          running_q, running_d;

  // Output register
  logic     out_valid_q, out_valid_d;
  out_req_t out_q;

  logic          accept;
  logic          fire;
  logic          slot_free;
  logic          s1_go;
  logic          last;
  logic [CW-1:0] next_idx;
  logic [CW-1:0] cur_d_inc;
  logic [CW+3:0] cur_ext;
  logic [IW+3:0] widx_ext;
  out_req_t      out_new;

  // Handshake: stall only when a firing split finds the output register full
  assign fire      = s1_v_q && (s1_op_q == OP_TICK) && running_q && (ticks_q <= TICKS_MIN);
  assign slot_free = !out_valid_q || out_ready_i;
  assign s1_go     = s1_v_q && (!fire || slot_free);
  assign in_ready_o = !s1_v_q || s1_go;
  assign accept    = in_valid_i && in_ready_o;

  // Chain index bookkeeping
  assign next_idx = cur_q + CW'(1);
  assign last     = !(next_idx < active_q);
  assign cur_ext  = {4'b0, cur_q};

  // Next chain state from the request in the stage
  always_comb begin
    active_d  = active_q;
    cur_d     = cur_q;
    ticks_d   = ticks_q;
    running_d = running_q;
    if (s1_go) begin
      unique case (s1_op_q)
        OP_WRITE: begin
        end
        OP_ARM: begin
          if (s1_cnt_q != 8'd0) begin
            if (32'(s1_cnt_q) > MAX_SPLITS) begin
              active_d = CW'(MAX_SPLITS);
            end else begin
              active_d = CW'(s1_cnt_q);
            end
            cur_d     = '0;
            ticks_d   = (ram_rdata_a_i.line != 8'd0) ? ram_rdata_a_i.line : TICKS_MIN;
            running_d = 1'b1;
          end
        end
        OP_TICK: begin
          if (running_q) begin
            if (!fire) begin
              ticks_d = ticks_q - 8'd1;
            end else begin
              cur_d = next_idx;
              if (!last) begin
                ticks_d = ram_rline_b_i - ram_rdata_a_i.line;
              end else begin
                running_d = 1'b0;
                ticks_d   = '0;
              end
            end
          end
        end
        OP_DISARM: begin
          running_d = 1'b0;
          ticks_d   = '0;
          active_d  = '0;
          cur_d     = '0;
        end
      endcase
    end
  end

  // Result of a firing split
  always_comb begin
    out_new.out_plane1_x = ram_rdata_a_i.p1x;
    out_new.out_plane1_y = ram_rdata_a_i.p1y;
    out_new.out_plane2_x = ram_rdata_a_i.p2x;
    out_new.out_plane2_y = ram_rdata_a_i.p2y;
    out_new.fired_split  = cur_ext[3:0];
    out_new.chain_done   = last;
  end

  assign s1_v_d      = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
  assign out_valid_d = (out_valid_q && !out_ready_i) || (s1_go && fire);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      active_q    <= '0;
      cur_q       <= '0;
      ticks_q     <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q      <= s1_v_d;
      active_q    <= active_d;
      cur_q       <= cur_d;
      ticks_q     <= ticks_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= in_req_i.operation;
      s1_cnt_q <= in_req_i.arm_count;
    end
    if (s1_go && fire) begin
      out_q <= out_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // Table reads use the state as it stands after the request ahead
  assign cur_d_inc     = cur_d + CW'(1);
  assign ram_re_o      = accept;
  assign ram_raddr_a_o = (in_req_i.operation == OP_ARM) ? '0 : cur_d[IW-1:0];
  assign ram_raddr_b_o = cur_d_inc[IW-1:0];

  // Table writes go in at acceptance, ahead of any later read
  assign widx_ext    = {{IW{1'b0}}, in_req_i.entry_index};
  assign ram_we_o    = accept && (in_req_i.operation == OP_WRITE) &&
                       (32'(in_req_i.entry_index) < MAX_SPLITS);
  assign ram_waddr_o = widx_ext[IW-1:0];
  always_comb begin
    ram_wdata_o.line = in_req_i.split_line;
    ram_wdata_o.p1x  = in_req_i.plane1_scroll_x;
    ram_wdata_o.p1y  = in_req_i.plane1_scroll_y;
    ram_wdata_o.p2x  = in_req_i.plane2_scroll_x;
    ram_wdata_o.p2y  = in_req_i.plane2_scroll_y;
  end

  // A running chain always points inside its own count
  a_running_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (cur_q < active_q) && (32'(active_q) <= MAX_SPLITS))
    else $error("running chain index out of range");

  // A split that cannot leave must hold off new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request accepted while a split result is blocked");

  // The last split of a chain stops it
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && fire && last) |=> !running_q && (ticks_q == 8'd0))
    else $error("chain still running after its last split");

  // A firing split always leaves a valid result in the output register
  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && fire) |=> out_valid_q)
    else $error("fired split lost");

endmodule

[test/tb_hblank_scroll_split_sequencer.sv]
// Testbench for hblank_scroll_split_sequencer: directed split chains, then random ones.
// Predicts each fired split from a behavioral copy of the table and chain state.
// Depends on hsss_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module tb_hblank_scroll_split_sequencer;
  import hsss_pkg::*;

  localparam int unsigned TBL_DEPTH   = 16;
  localparam int unsigned TOTAL_ITEMS = 1630;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  out_req_t out_req;

  bit          quiet = 1'b0;    // no idling on either side
  int unsigned idle_pct = 30;   // chance of a sender gap after a request
  int unsigned stall_left = 0;
  int unsigned requests_sent = 0;
  int unsigned chains_started = 0;

  // Tracks table and chain state, queues the scroll results each tick should fire
  class split_chain_tracker;
    entry_t      split_tbl [TBL_DEPTH];
    int unsigned armed_count;
    int unsigned cur_split;
    logic [7:0]  ticks_left;
    bit          running;
    out_req_t    pending_scrolls [$];
    int unsigned errors;
    int unsigned splits_fired;
    int unsigned chains_done;

    function entry_t read_slot(int unsigned idx);
      entry_t blank;
      blank = '0;
      if (idx < TBL_DEPTH) return split_tbl[idx];
      return blank;
    endfunction

    // Apply one accepted request to the predicted state
    function void take_request(in_req_t r);
      entry_t      cur;
      entry_t      nxt;
      out_req_t    res;
      int unsigned cnt;
      case (r.operation)
        OP_WRITE: begin
          if (r.entry_index < TBL_DEPTH)
            split_tbl[r.entry_index] = '{line: r.split_line, p1x: r.plane1_scroll_x,
                                         p1y: r.plane1_scroll_y, p2x: r.plane2_scroll_x,
                                         p2y: r.plane2_scroll_y};
        end
        OP_ARM: begin
          if (r.arm_count != 8'd0) begin
            cnt = (r.arm_count > TBL_DEPTH) ? TBL_DEPTH : r.arm_count;
            armed_count = cnt;
            cur_split = 0;
            ticks_left = (read_slot(0).line != 8'd0) ? read_slot(0).line : TICKS_MIN;
            running = 1'b1;
          end
        end
        OP_DISARM: begin
          running = 1'b0;
          ticks_left = 8'd0;
          armed_count = 0;
          cur_split = 0;
        end
        OP_TICK: begin
          if (running) begin
            if (ticks_left > 8'd1) begin
              ticks_left--;
            end else begin
              cur = read_slot(cur_split);
              res.out_plane1_x = cur.p1x;
              res.out_plane1_y = cur.p1y;
              res.out_plane2_x = cur.p2x;
              res.out_plane2_y = cur.p2y;
              res.fired_split  = 4'(cur_split);
              cur_split++;
              if (cur_split < armed_count) begin
                nxt = read_slot(cur_split);
                // 8-bit wrapped line distance; zero fires on the next tick
                ticks_left = nxt.line - cur.line;
                res.chain_done = 1'b0;
              end else begin
                running = 1'b0;
                ticks_left = 8'd0;
                res.chain_done = 1'b1;
              end
              pending_scrolls.push_back(res);
            end
          end
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest expected split
    function void match_scroll(out_req_t act);
      out_req_t want;
      if (pending_scrolls.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        return;
      end
      want = pending_scrolls.pop_front();
      splits_fired++;
      if (want.chain_done) chains_done++;
      cmp_field("plane1 x", want.out_plane1_x, act.out_plane1_x);
      cmp_field("plane1 y", want.out_plane1_y, act.out_plane1_y);
      cmp_field("plane2 x", want.out_plane2_x, act.out_plane2_x);
      cmp_field("plane2 y", want.out_plane2_y, act.out_plane2_y);
      cmp_field("fired split", {4'h0, want.fired_split}, {4'h0, act.fired_split});
      cmp_field("chain done", {7'h0, want.chain_done}, {7'h0, act.chain_done});
    endfunction
  endclass

  split_chain_tracker sb = new();

  hblank_scroll_split_sequencer #(
    .MAX_SPLITS(TBL_DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  always #5 clk = ~clk;

  // Result side: check on handshake, random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_scroll(out_req);
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_req_t random_request();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_req_t)-1:0];
  endfunction

  // Present one request, hold it until taken, then maybe leave a gap
  task automatic send_request(input in_req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    sb.take_request(r);
    requests_sent++;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_op(input op_e op, input logic [7:0] cnt);
    in_req_t r;
    r = random_request();
    r.operation = op;
    r.arm_count = cnt;
    send_request(r);
  endtask

  // Hold off the sender until every predicted split has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_scrolls.size() != 0) @(posedge clk);
  endtask

  // Any operation with random content; writes lean toward short lines
  task automatic send_noise();
    in_req_t r;
    r = random_request();
    if (r.operation == OP_WRITE && $urandom_range(0, 1) == 1)
      r.split_line = 8'($urandom_range(0, 8));
    send_request(r);
  endtask

  // Program a well-formed chain from slot 0, arm it and tick it through
  task automatic run_chain();
    in_req_t     r;
    int unsigned len;
    int unsigned n;
    logic [7:0]  ln;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    // a few chains start near the top of the line range so the deltas wrap
    ln = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(240, 255))
                                      : 8'($urandom_range(0, 4));
    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
    chains_started++;
    for (int i = 0; i < len; i++) begin
      r = random_request();
      r.operation   = OP_WRITE;
      r.entry_index = 4'(i);
      r.split_line  = ln;
      send_request(r);
      ln += 8'($urandom_range(0, 3));
    end
    r = random_request();
    r.operation = OP_ARM;
    if ($urandom_range(0, 19) != 0) r.arm_count = 8'(len);
    send_request(r);
    n = 0;
    while (sb.running && n < 600) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      else send_op(OP_TICK, 8'($urandom));
      n++;
    end
  endtask

  initial begin
    in_req_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick while stopped, fill the whole table
    send_op(OP_TICK, 8'h01);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      r = random_request();
      r.operation       = OP_WRITE;
      r.entry_index     = 4'(i);
      r.split_line      = (i == 1) ? 8'd0 : (i == TBL_DEPTH - 1) ? 8'hFF : 8'(i);
      r.plane1_scroll_x = 8'(i * 17);
      r.plane1_scroll_y = ~8'(i * 17);
      r.plane2_scroll_x = 8'(i << 4);
      r.plane2_scroll_y = 8'(255 - i * 16);
      send_request(r);
    end
    // zero count ignored; first line zero and zero delta; tick after chain end
    send_op(OP_ARM, 8'd0);
    send_op(OP_ARM, 8'd2);
    send_op(OP_TICK, 8'h00);
    send_op(OP_TICK, 8'hFF);
    send_op(OP_TICK, 8'h00);
    // clamped count, re-arm while running, disarm
    send_op(OP_ARM, 8'hFF);
    send_op(OP_TICK, 8'h00);
    send_op(OP_TICK, 8'h00);
    send_op(OP_ARM, 8'd3);
    send_op(OP_TICK, 8'h00);
    send_op(OP_DISARM, 8'h05);
    send_op(OP_TICK, 8'h00);
    drain_results();

    // Random: mostly well-formed chains, some noise and sender hold-offs
    while (requests_sent < TOTAL_ITEMS) begin
      quiet = (requests_sent > TOTAL_ITEMS - 200);
      if (quiet) idle_pct = 0;
      if ($urandom_range(0, 9) < 7) run_chain();
      else send_noise();
      if (!quiet && $urandom_range(0, 9) == 0) drain_results();
    end
    in_valid <= 1'b0;

    while (sb.pending_scrolls.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d requests over %0d random chains; %0d splits fired, %0d chain ends.",
             requests_sent, chains_started, sb.splits_fired, sb.chains_done);
    $display("Covered wrapped and zero line deltas, clamped counts, re-arm and disarm.");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d splits still expected", $time, sb.pending_scrolls.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
